// File: rtl/core/ppt_pkg.sv
package ppt_pkg;

    // Width of one slice of the multiplicand handled per multiplier cycle
    localparam int MUL_CHUNK = 32;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_KSTART,
        S_TRIAL,
        S_MUL
    } t_state;

endpackage

// File: rtl/core/ppt_mul.sv
module ppt_mul #(
    parameter int A_BITS = 31,
    parameter int B_BITS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  logic [A_BITS-1:0]                       i_a,
    input  logic [B_BITS-1:0]                       i_b,
    output logic                                    o_done,
    output logic [((A_BITS + ppt_pkg::MUL_CHUNK - 1) / ppt_pkg::MUL_CHUNK)
                  * ppt_pkg::MUL_CHUNK + B_BITS - 1:0] o_prod
);

    localparam int MW    = ppt_pkg::MUL_CHUNK;
    localparam int STEPS = (A_BITS + MW - 1) / MW;
    localparam int PADW  = STEPS * MW;
    localparam int PW    = PADW + B_BITS;
    localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic [PADW-1:0]      r_a;
    logic [B_BITS-1:0]    r_b;
    logic [PW-1:0]        r_acc;
    logic [PW-1:0]        n_acc;
    logic [SW-1:0]        r_left;
    logic                 r_busy;
    logic                 r_done;
    logic [MW+B_BITS-1:0] partial;

    // One chunk-by-base product per cycle, most significant chunk first
    assign partial = (MW + B_BITS)'(r_a[PADW-1 -: MW]) * (MW + B_BITS)'(r_b);
    assign n_acc   = (r_acc << MW) + PW'(partial);

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_left <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_left <= SW'(STEPS - 1);
            end else if (r_busy) begin
                if (r_left == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_left <= r_left - 1'b1;
                end
            end
        end
    end

    // Operands and running sum
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= PADW'(i_a) << (PADW - A_BITS);
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_a   <= r_a << MW;
            r_acc <= n_acc;
        end
    end

    // Sum is shifted up by PADW-A_BITS bits through the padded operand; undo on output
    assign o_prod = r_acc >> (PADW - A_BITS);
    assign o_done = r_done;

endmodule

// File: rtl/core/perfect_power_test_core.sv
// Perfect power test: one transaction takes a signed VALUE_BITS-bit value and,
// after a variable number of cycles, pulses o_done for exactly one cycle with
// o_is_perfect_power set if the value equals b^k for some b >= 2, k >= 2.
// The receiver cannot stall, so o_is_perfect_power must be captured in the
// cycle o_done is high. busy is high from the accepting edge until the cycle
// o_done rises; a new start is taken in that same cycle. Negative values, zero
// and one never raise busy and give o_done in the next cycle. Otherwise every
// exponent k from 2 to VALUE_BITS-1 runs a bit-by-bit root search over
// (VALUE_BITS)/2 candidate bits; each candidate is raised to k through one
// shared multiplier, stopping early once the power passes the value. The time
// is set by that multiplier loop and is shorter when an exact root turns up
// early.
module perfect_power_test_core #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  busy,
    output logic                  o_done,
    output logic                  o_is_perfect_power
);

    localparam int AW    = VALUE_BITS - 1;
    localparam int BW    = (AW + 1) / 2;
    localparam int KW    = $clog2(VALUE_BITS);
    localparam int BIW   = $clog2(BW);
    localparam int MW    = ppt_pkg::MUL_CHUNK;
    localparam int PX    = ((AW + MW - 1) / MW) * MW + BW;

    ppt_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_n, n_n;
    logic [KW-1:0]   r_k, n_k;
    logic [KW-1:0]   r_cnt, n_cnt;
    logic [BIW-1:0]  r_bit, n_bit;
    logic [BW-1:0]   r_root, n_root;
    logic            r_done, n_done;
    logic            r_result, n_result;

    logic [BW-1:0]   cand;
    logic [PX-1:0]   n_ext;
    logic            mul_start;
    logic [AW-1:0]   mul_a;
    logic            mul_done;
    logic [PX-1:0]   mul_prod;
    logic            resolve;
    logic            keep;

    assign cand  = r_root | (BW'(1) << r_bit);
    assign n_ext = PX'(r_n);

    // Shared multiplier: running power times candidate base
    ppt_mul #(
        .A_BITS (AW),
        .B_BITS (BW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (cand),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppt_pkg::S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_k      <= n_k;
        r_cnt    <= n_cnt;
        r_bit    <= n_bit;
        r_root   <= n_root;
        r_result <= n_result;
    end

    // Sequencer: exponent loop, root bit loop, power loop
    always_comb begin
        n_state   = r_state;
        n_n       = r_n;
        n_k       = r_k;
        n_cnt     = r_cnt;
        n_bit     = r_bit;
        n_root    = r_root;
        n_done    = 1'b0;
        n_result  = r_result;
        mul_start = 1'b0;
        mul_a     = AW'(cand);
        resolve   = 1'b0;
        keep      = 1'b0;

        unique case (r_state)
            ppt_pkg::S_IDLE: begin
                if (start) begin
                    n_n = i_value[AW-1:0];
                    // sign set, zero or one: never a perfect power
                    if (i_value[AW] || (i_value[AW-1:0] <= AW'(1))) begin
                        n_done   = 1'b1;
                        n_result = 1'b0;
                    end else begin
                        n_k     = KW'(2);
                        n_state = ppt_pkg::S_KSTART;
                    end
                end
            end
            ppt_pkg::S_KSTART: begin
                n_root  = '0;
                n_bit   = BIW'(BW - 1);
                n_state = ppt_pkg::S_TRIAL;
            end
            ppt_pkg::S_TRIAL: begin
                if (PX'(cand) > n_ext) begin
                    resolve = 1'b1;
                end else begin
                    mul_start = 1'b1;
                    mul_a     = AW'(cand);
                    n_cnt     = KW'(1);
                    n_state   = ppt_pkg::S_MUL;
                end
            end
            ppt_pkg::S_MUL: begin
                if (mul_done) begin
                    if (mul_prod > n_ext) begin
                        resolve = 1'b1;
                    end else if (r_cnt + 1'b1 == r_k) begin
                        if (mul_prod == n_ext) begin
                            n_done   = 1'b1;
                            n_result = 1'b1;
                            n_state  = ppt_pkg::S_IDLE;
                        end else begin
                            resolve = 1'b1;
                            keep    = 1'b1;
                        end
                    end else begin
                        mul_start = 1'b1;
                        mul_a     = mul_prod[AW-1:0];
                        n_cnt     = r_cnt + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ppt_pkg::S_IDLE;
            end
        endcase

        // Trial finished: keep the bit if the power stayed below, then advance
        if (resolve) begin
            if (keep) begin
                n_root = cand;
            end
            if (r_bit == '0) begin
                if (r_k == KW'(AW)) begin
                    n_done   = 1'b1;
                    n_result = 1'b0;
                    n_state  = ppt_pkg::S_IDLE;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = ppt_pkg::S_KSTART;
                end
            end else begin
                n_bit   = r_bit - 1'b1;
                n_state = ppt_pkg::S_TRIAL;
            end
        end
    end

    assign busy               = (r_state != ppt_pkg::S_IDLE);
    assign o_done             = r_done;
    assign o_is_perfect_power = r_result;

endmodule

// File: sim/tb_perfect_power_test_core.sv
`timescale 1ns / 1ps

module tb_perfect_power_test_core;

    localparam int VALUE_BITS = 32;
    localparam int N_RANDOM = 560;
    localparam int STALL_LIMIT = 40000;
    localparam int SETTLE_CYCLES = 64;
    localparam longint unsigned VALUE_MAX = 64'h7FFF_FFFF;

    // One pending verdict: the value sent and whether it is b^k
    typedef struct {
        logic [VALUE_BITS-1:0] value;
        bit                    power;
    } t_verdict;

    // Directed row; known marks a verdict typed in by hand
    typedef struct {
        logic [VALUE_BITS-1:0] value;
        bit                    known;
        bit                    power;
    } t_probe;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic [VALUE_BITS-1:0] i_value;
    logic                  busy;
    logic                  o_done;
    logic                  o_is_perfect_power;

    t_verdict verdicts[$];
    int       err_count = 0;
    int       n_checked = 0;
    int       n_powers = 0;
    int       n_directed = 0;
    int       n_random = 0;
    int       stall_cycles = 0;
    bit       no_idle = 1'b0;

    t_probe probe_table [24] = '{
        '{32'd0,          1'b1, 1'b0},
        '{32'd1,          1'b1, 1'b0},
        '{32'hFFFF_FFFF,  1'b1, 1'b0},
        '{32'h8000_0000,  1'b1, 1'b0},
        '{32'h7FFF_FFFF,  1'b0, 1'b0},
        '{32'd2,          1'b1, 1'b0},
        '{32'd3,          1'b0, 1'b0},
        '{32'd4,          1'b1, 1'b1},
        '{32'd6,          1'b0, 1'b0},
        '{32'd8,          1'b1, 1'b1},
        '{32'd9,          1'b1, 1'b1},
        '{32'd16,         1'b1, 1'b1},
        '{32'd65536,      1'b1, 1'b1},
        '{32'h4000_0000,  1'b1, 1'b1},
        '{32'd1073741823, 1'b0, 1'b0},
        '{32'd1073741825, 1'b0, 1'b0},
        '{32'd2147395600, 1'b0, 1'b0},
        '{32'd2147395601, 1'b0, 1'b0},
        '{32'd1162261467, 1'b0, 1'b0},
        '{32'd1977326743, 1'b0, 1'b0},
        '{32'd2146689000, 1'b0, 1'b0},
        '{32'd2147483629, 1'b0, 1'b0},
        '{32'h8000_0004,  1'b1, 1'b0},
        '{32'hC000_0000,  1'b1, 1'b0}
    };

    perfect_power_test_core #(
        .VALUE_BITS(VALUE_BITS)
    ) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .i_value            (i_value),
        .busy               (busy),
        .o_done             (o_done),
        .o_is_perfect_power (o_is_perfect_power)
    );

    // 100 MHz clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Order of b^k against n: -1 below, 0 equal, 1 above; stops once past n
    function automatic int pow_order(longint unsigned b, int k, longint unsigned n);
        longint unsigned acc;
        acc = 1;
        for (int i = 0; i < k; i++) begin
            acc = acc * b;
            if (acc > n)
                return 1;
        end
        return (acc == n) ? 0 : -1;
    endfunction

    // Floor of the k-th root of n (n below 2^31, so the root fits in 16 bits)
    function automatic longint unsigned root_floor(longint unsigned n, int k);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 1;
        hi = 65536;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (pow_order(mid, k, n) <= 0)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    // Expected verdict: nonnegative and an exact k-th power of a base >= 2
    function automatic bit predict_power(logic [VALUE_BITS-1:0] v);
        longint unsigned n;
        longint unsigned r;
        n = longint'(v);
        if (v[VALUE_BITS-1] || n <= 1)
            return 1'b0;
        for (int k = 2; k < VALUE_BITS; k++) begin
            r = root_floor(n, k);
            if (r >= 2 && pow_order(r, k, n) == 0)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Random value: exact powers, their neighbors, negatives, tiny and plain values
    function automatic logic [VALUE_BITS-1:0] make_value();
        int                    pick;
        int                    k;
        longint unsigned       cap;
        longint unsigned       base;
        longint unsigned       p;
        logic [VALUE_BITS-1:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            v = {1'b1, 31'($urandom)};
        end else if (pick < 18) begin
            v = 32'($urandom_range(0, 3));
        end else if (pick < 65) begin
            k = $urandom_range(2, 30);
            cap = root_floor(VALUE_MAX, k);
            base = 2 + ($urandom % (cap - 1));
            p = 1;
            for (int i = 0; i < k; i++)
                p = p * base;
            v = 32'(p);
            // Off-by-one neighbors of an exact power
            if (pick >= 50)
                v = $urandom_range(0, 1) ? v + 32'd1 : v - 32'd1;
        end else begin
            v = $urandom >> $urandom_range(1, 31);
        end
        return v;
    endfunction

    // Gap after a transaction: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Present one value until taken, queue its verdict, then idle for a random gap that may be zero
    task automatic send_value(logic [VALUE_BITS-1:0] v, bit known, bit power);
        t_verdict entry;
        int       gap;
        start <= 1'b1;
        i_value <= v;
        do
            @(posedge i_clk);
        while (busy);
        entry.value = v;
        entry.power = known ? power : predict_power(v);
        verdicts.push_back(entry);
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) begin
                i_value <= $urandom;
                @(posedge i_clk);
            end
        end
    endtask

    // Result check against the oldest pending verdict
    always @(posedge i_clk) begin : result_check
        t_verdict head;
        if (i_rst_n && o_done) begin
            if (verdicts.size() == 0) begin
                $error("unexpected result: is_perfect_power=%0d", o_is_perfect_power);
                err_count++;
            end else begin
                head = verdicts.pop_front();
                n_checked++;
                n_powers += head.power;
                if (o_is_perfect_power !== head.power) begin
                    $error("is_perfect_power for value %0d: expected %0d, actual %0d",
                           $signed(head.value), head.power, o_is_perfect_power);
                    err_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stimulus: reset, directed table, random values, drain
    initial begin : stimulus
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_value <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (probe_table[i]) begin
            send_value(probe_table[i].value, probe_table[i].known, probe_table[i].power);
            n_directed++;
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            // Switch between idling and back-to-back stretches
            if (i % 40 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            send_value(make_value(), 1'b0, 1'b0);
            n_random++;
        end
        start <= 1'b0;

        while (verdicts.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (verdicts.size() != 0) begin
            $error("%0d results never arrived", verdicts.size());
            err_count++;
        end

        $display("Sent %0d directed and %0d random values; %0d verdicts checked.",
                 n_directed, n_random, n_checked);
        $display("Perfect powers among them: %0d; mismatches: %0d.", n_powers, err_count);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
